>>> rtl/core/aes128d_pkg.sv
package aes128d_pkg;

    localparam int ROUNDS    = 10;
    localparam int RK_CNT    = ROUNDS + 1;
    localparam int RK_IDX_W  = $clog2(RK_CNT);
    localparam int BLK_W     = 128;
    localparam int HALF_W    = 64;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_ROUND
    } t_state;

    localparam logic [2047:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[8 * (255 - int'(b)) +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        return INV_SBOX[8 * (255 - int'(b)) +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

>>> rtl/core/aes128d_kexp.sv
module aes128d_kexp
    import aes128d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic                i_cfg_idx,
    input  logic [HALF_W-1:0]   i_cfg_wdata,
    input  logic [RK_IDX_W-1:0] i_rk_idx,
    output logic [BLK_W-1:0]    o_rk,
    output logic                o_busy
);

    logic [HALF_W-1:0]   r_key_high;
    logic [HALF_W-1:0]   r_key_low;
    logic [BLK_W-1:0]    r_store [RK_CNT];
    logic [BLK_W-1:0]    r_rk;
    logic [7:0]          r_rcon;
    logic [RK_IDX_W-1:0] r_cnt;
    logic                r_busy;

    logic [BLK_W-1:0] n_key;
    logic [31:0]      rot_sub;
    logic [31:0]      n0, n1, n2, n3;

    // key as it stands after this write
    always_comb begin
        n_key = {r_key_high, r_key_low};
        unique case (i_cfg_idx)
            CFG_KEY_HIGH: n_key[127:64] = i_cfg_wdata;
            CFG_KEY_LOW:  n_key[63:0]   = i_cfg_wdata;
            default:      n_key = {r_key_high, r_key_low};
        endcase
    end

    // one schedule step: next round key from current
    always_comb begin
        rot_sub = sub_word({r_rk[23:0], r_rk[31:24]}) ^ {r_rcon, 24'h0};
        n0      = r_rk[127:96] ^ rot_sub;
        n1      = r_rk[95:64] ^ n0;
        n2      = r_rk[63:32] ^ n1;
        n3      = r_rk[31:0] ^ n2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_busy     <= 1'b0;
            r_cnt      <= '0;
            r_rcon     <= 8'h01;
        end else if (i_cfg_wen) begin
            r_key_high <= n_key[127:64];
            r_key_low  <= n_key[63:0];
            r_busy     <= 1'b1;
            r_cnt      <= RK_IDX_W'(1);
            r_rcon     <= 8'h01;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + RK_IDX_W'(1);
            r_rcon <= xtime(r_rcon);
            if (r_cnt == RK_IDX_W'(ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_wen) begin
            r_store[0] <= n_key;
            r_rk       <= n_key;
        end else if (r_busy) begin
            r_store[r_cnt] <= {n0, n1, n2, n3};
            r_rk           <= {n0, n1, n2, n3};
        end
    end

    assign o_rk   = r_store[i_rk_idx];
    assign o_busy = r_busy;

endmodule

>>> rtl/core/aes128d_round.sv
module aes128d_round
    import aes128d_pkg::*;
(
    input  logic [BLK_W-1:0] i_state,
    input  logic [BLK_W-1:0] i_rk,
    input  logic             i_last,
    output logic [BLK_W-1:0] o_state
);

    logic [7:0]       b  [16];
    logic [7:0]       t  [16];
    logic [BLK_W-1:0] ak;
    logic [7:0]       a0, a1, a2, a3;
    logic [7:0]       x2 [4];
    logic [7:0]       x4 [4];
    logic [7:0]       x8 [4];
    logic [BLK_W-1:0] mix;

    // InvShiftRows + InvSubBytes + AddRoundKey: row r, column c moves to column (c + r) mod 4
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            b[i] = i_state[127 - 8 * i -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[4 * ((c + r) % 4) + r] = inv_sbox(b[4 * c + r]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            ak[127 - 8 * i -: 8] = t[i] ^ i_rk[127 - 8 * i -: 8];
        end
    end

    // InvMixColumns, multiples 9/11/13/14 built from xtime chains
    always_comb begin
        mix = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                x2[k] = xtime(ak[127 - 8 * (4 * c + k) -: 8]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            a0 = ak[127 - 32 * c -: 8];
            a1 = ak[119 - 32 * c -: 8];
            a2 = ak[111 - 32 * c -: 8];
            a3 = ak[103 - 32 * c -: 8];
            mix[127 - 32 * c -: 8] = (x8[0] ^ x4[0] ^ x2[0]) ^ (x8[1] ^ x2[1] ^ a1)
                                   ^ (x8[2] ^ x4[2] ^ a2) ^ (x8[3] ^ a3);
            mix[119 - 32 * c -: 8] = (x8[0] ^ a0) ^ (x8[1] ^ x4[1] ^ x2[1])
                                   ^ (x8[2] ^ x2[2] ^ a2) ^ (x8[3] ^ x4[3] ^ a3);
            mix[111 - 32 * c -: 8] = (x8[0] ^ x4[0] ^ a0) ^ (x8[1] ^ a1)
                                   ^ (x8[2] ^ x4[2] ^ x2[2]) ^ (x8[3] ^ x2[3] ^ a3);
            mix[103 - 32 * c -: 8] = (x8[0] ^ x2[0] ^ a0) ^ (x8[1] ^ x4[1] ^ a1)
                                   ^ (x8[2] ^ a2) ^ (x8[3] ^ x4[3] ^ x2[3]);
        end
    end

    assign o_state = i_last ? ak : mix;

endmodule

>>> rtl/core/aes128_block_decrypt_top.sv
// AES-128 block decryption through a shared round unit, one round per cycle; the
// final round waits while the output register is still full. Steps: whitening on
// accept, 9 full rounds, final round straight into the output register.
// s_axis_tready is low while a block is in the round loop and while the key
// schedule runs after each key register write.
// Reset (i_rst_n low, synchronous): key registers cleared, FSM idle, no result.
module aes128_block_decrypt_top
    import aes128d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: index 0 key_high, 1 key_low
    input  logic               i_cfg_wen,
    input  logic               i_cfg_idx,
    input  logic [HALF_W-1:0]  i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BLK_W-1:0]   s_axis_tdata,   // [63:0] cipher_high, [127:64] cipher_low
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [BLK_W-1:0]   m_axis_tdata    // [63:0] plain_high, [127:64] plain_low
);

    t_state              r_state, n_state;
    logic [BLK_W-1:0]    r_data, n_data;
    logic [RK_IDX_W-1:0] r_round, n_round;
    logic [BLK_W-1:0]    r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                kexp_busy;
    logic [RK_IDX_W-1:0] rk_idx;
    logic [BLK_W-1:0]    rk;
    logic [BLK_W-1:0]    rnd_out;
    logic [BLK_W-1:0]    in_blk;
    logic                in_xact;
    logic                out_free;

    // key schedule and round key store
    aes128d_kexp u_kexp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rk_idx    (rk_idx),
        .o_rk        (rk),
        .o_busy      (kexp_busy)
    );

    // shared round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns unless last
    aes128d_round u_round (
        .i_state (r_data),
        .i_rk    (rk),
        .i_last  (r_round == '0),
        .o_state (rnd_out)
    );

    // byte 0 of the block in the top bits
    assign in_blk        = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign s_axis_tready = (r_state == ST_IDLE) && !kexp_busy;
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    // idle: last round key for the initial whitening
    assign rk_idx        = (r_state == ST_IDLE) ? RK_IDX_W'(ROUNDS) : r_round;

    always_comb begin
        n_state     = r_state;
        n_data      = r_data;
        n_round     = r_round;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_xact) begin
                    n_data  = in_blk ^ rk;
                    n_round = RK_IDX_W'(ROUNDS - 1);
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round != '0) begin
                    n_data  = rnd_out;
                    n_round = r_round - RK_IDX_W'(1);
                end else if (out_free) begin
                    // final round lands straight in the output register
                    n_out       = {rnd_out[63:0], rnd_out[127:64]};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_round     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_round     <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

>>> tb/sv/aes128_block_decrypt_top_tb.sv
module aes128_block_decrypt_top_tb
    import aes128d_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 8;
    localparam int RAND_ITEMS  = 104;   // per phase
    localparam int DRAIN_WAIT  = 30;    // covers a block's decryption plus key schedule
    localparam int CYCLE_LIMIT = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wen;
    logic              i_cfg_idx;
    logic [HALF_W-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BLK_W-1:0]  s_axis_tdata;   // [63:0] cipher_high, [127:64] cipher_low
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BLK_W-1:0]  m_axis_tdata;   // [63:0] plain_high, [127:64] plain_low

    aes128_block_decrypt_top dut (.*);

    // stimulus and scoreboard
    logic [BLK_W-1:0] cipher_q[$];     // blocks waiting to be driven
    logic [BLK_W-1:0] plain_q[$];      // expected plaintext, oldest first
    logic             in_taken;        // input transaction at the last rising edge
    int               send_idle_pct;
    int               recv_stall_pct;
    int               mismatches;
    int               cycles;

    // predictor state
    logic [7:0]        fwd_tab[256];
    logic [7:0]        inv_tab[256];
    logic [HALF_W-1:0] key_hi, key_lo;
    logic [HALF_W-1:0] sched[22];      // entry 2r: round key r bytes 0..7, 2r+1: bytes 8..15

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[0]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return acc;
    endfunction

    // S-box pair from the field inverse (x^254) and the affine map
    function automatic void build_boxes();
        logic [7:0] inv, base, s;
        for (int x = 0; x < 256; x++) begin
            inv  = 8'h01;
            base = x[7:0];
            for (int e = 0; e < 7; e++) begin
                base = gmul(base, base);
                inv  = gmul(inv, base);
            end
            if (x == 0) inv = 8'h00;
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = x[7:0];
        end
    endfunction

    function automatic void derive_round_keys();
        logic [31:0] w[44];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        w[0] = key_hi[63:32];
        w[1] = key_hi[31:0];
        w[2] = key_lo[63:32];
        w[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]}
                    ^ {rcon, 24'h0};
                rcon = gmul(rcon, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) begin
            sched[2*r]   = {w[4*r],   w[4*r+1]};
            sched[2*r+1] = {w[4*r+2], w[4*r+3]};
        end
    endfunction

    // returns {plain_low, plain_high}, same packing as tdata
    function automatic logic [BLK_W-1:0] decrypt_block(input logic [BLK_W-1:0] blk);
        logic [7:0]        st[16];
        logic [7:0]        tmp[16];
        logic [7:0]        a0, a1, a2, a3;
        logic [HALF_W-1:0] hi, lo;
        for (int i = 0; i < 8; i++) begin
            st[i]   = blk[63 - 8*i -: 8];
            st[8+i] = blk[127 - 8*i -: 8];
        end
        for (int r = 10; r >= 0; r--) begin
            for (int i = 0; i < 8; i++) begin
                st[i]   ^= sched[2*r][63 - 8*i -: 8];
                st[8+i] ^= sched[2*r+1][63 - 8*i -: 8];
            end
            if (r != 10 && r != 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
                                ^ gmul(a3, 8'd9);
                    st[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
                                ^ gmul(a3, 8'd13);
                    st[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
                                ^ gmul(a3, 8'd11);
                    st[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
                                ^ gmul(a3, 8'd14);
                end
            end
            if (r != 0) begin
                // row r byte shifts right by r columns, then inverse S-box
                for (int rw = 0; rw < 4; rw++)
                    for (int c = 0; c < 4; c++)
                        tmp[4*((c + rw) % 4) + rw] = st[4*c + rw];
                for (int i = 0; i < 16; i++) st[i] = inv_tab[tmp[i]];
            end
        end
        for (int i = 0; i < 8; i++) begin
            hi[63 - 8*i -: 8] = st[i];
            lo[63 - 8*i -: 8] = st[8+i];
        end
        return {lo, hi};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // input driver: new transaction only after the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (cipher_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata  <= cipher_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge i_clk) begin
        logic [BLK_W-1:0] want;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            plain_q.push_back(decrypt_block(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (plain_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: plain_high %h plain_low %h",
                             m_axis_tdata[63:0], m_axis_tdata[127:64]);
            end else begin
                want = plain_q.pop_front();
                if (m_axis_tdata[63:0] !== want[63:0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plain_high mismatch: exp %h got %h",
                                 want[63:0], m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[127:64] !== want[127:64]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plain_low mismatch: exp %h got %h",
                                 want[127:64], m_axis_tdata[127:64]);
                end
            end
        end
    end

    // key register write; block is idle whenever this runs
    task automatic write_key(input logic idx, input logic [HALF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_KEY_HIGH) key_hi = val;
        else                     key_lo = val;
        derive_round_keys();
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // wait until every block is sent and answered, then let the core settle
    task automatic drain();
        while (cipher_q.size() > 0 || s_axis_tvalid || plain_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [BLK_W-1:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wen      = 1'b0;
        i_cfg_idx      = CFG_KEY_HIGH;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        in_taken       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        cycles         = 0;
        key_hi         = '0;
        key_lo         = '0;
        build_boxes();
        derive_round_keys();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // idle mix rotates: none, sender idle, receiver stall, both light
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase

            // key choices: standard test key, extremes, then random and partial updates
            case (ph)
                0: begin
                    write_key(CFG_KEY_HIGH, 64'h0001020304050607);
                    write_key(CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
                end
                1: begin
                    write_key(CFG_KEY_HIGH, '1);
                    write_key(CFG_KEY_LOW,  '1);
                end
                2: begin
                    write_key(CFG_KEY_LOW,  '0);
                    write_key(CFG_KEY_HIGH, '0);
                end
                4: write_key(CFG_KEY_LOW, {$urandom, $urandom});   // only one half changes
                6: write_key(CFG_KEY_HIGH, {$urandom, $urandom});
                default: begin
                    write_key(CFG_KEY_HIGH, {$urandom, $urandom});
                    write_key(CFG_KEY_LOW,  {$urandom, $urandom});
                end
            endcase

            if (ph == 0) begin
                // known-answer block, field extremes, alternating and walking patterns
                cipher_q.push_back({64'hd8cdb78070b4c55a, 64'h69c4e0d86a7b0430});
                cipher_q.push_back('0);
                cipher_q.push_back('1);
                cipher_q.push_back({64'h0, {64{1'b1}}});
                cipher_q.push_back({{64{1'b1}}, 64'h0});
                cipher_q.push_back({64{2'b01}});
                cipher_q.push_back({64{2'b10}});
                for (int b = 0; b < 128; b += 9)
                    cipher_q.push_back(128'h1 << b);
                cipher_q.push_back(128'h1 << 127);
            end
            for (int n = 0; n < RAND_ITEMS; n++)
                cipher_q.push_back(rand_block());
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
